// ----- design/vvclld_pkg.sv -----
// ----------------------------------------------------------------------------
// vvclld_pkg
// Types, coefficient tables and helpers shared by the long luma deblocking
// line filter.
// ----------------------------------------------------------------------------
package vvclld_pkg;

    localparam int BIT_DEPTH_DEFAULT = 10;
    localparam int WORD_W            = 40;   // packed field width
    localparam int TC_W              = 10;
    localparam int LEN_W             = 3;
    localparam int SIDE_N            = 8;    // samples per side in one line
    localparam int LANE_N            = 7;    // longest filtered run per side
    localparam int DCOEF_W           = 6;
    localparam int TCOEF_W           = 3;
    localparam int CLIP_W            = 12;   // (tc * 6) >> 1 fits here

    localparam logic [LEN_W-1:0] LEN_CODE_5 = 3'd5;
    localparam logic [LEN_W-1:0] LEN_CODE_7 = 3'd7;

    typedef enum logic [1:0] {
        LEN3,
        LEN5,
        LEN7
    } len_t;

    typedef struct packed {
        logic [WORD_W-1:0] p_near;
        logic [WORD_W-1:0] p_far;
        logic [WORD_W-1:0] q_near;
        logic [WORD_W-1:0] q_far;
        logic [TC_W-1:0]   tc;
        logic [LEN_W-1:0]  p_length;
        logic [LEN_W-1:0]  q_length;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] p_near_out;
        logic [WORD_W-1:0] p_far_out;
        logic [WORD_W-1:0] q_near_out;
        logic [WORD_W-1:0] q_far_out;
    } out_item_t;

    // Per-line control that follows the samples down the pipe
    typedef struct packed {
        logic active;   // false for the 3/3 pair: line passes through
        len_t p_len;
        len_t q_len;
    } ctrl_t;

    localparam logic [DCOEF_W-1:0] DCOEF7 [7] = '{6'd59, 6'd50, 6'd41, 6'd32,
                                                  6'd23, 6'd14, 6'd5};
    localparam logic [DCOEF_W-1:0] DCOEF5 [5] = '{6'd58, 6'd45, 6'd32, 6'd19, 6'd6};
    localparam logic [DCOEF_W-1:0] DCOEF3 [3] = '{6'd53, 6'd32, 6'd11};
    localparam logic [TCOEF_W-1:0] TCOEF7 [7] = '{3'd6, 3'd5, 3'd4, 3'd3,
                                                  3'd2, 3'd1, 3'd1};
    localparam logic [TCOEF_W-1:0] TCOEF3 [3] = '{3'd6, 3'd4, 3'd2};

    // Lengths other than 5 and 7 count as 3
    function automatic len_t norm_len(input logic [LEN_W-1:0] code);
        len_t r;
        r = LEN3;
        if (code == LEN_CODE_7)
            r = LEN7;
        else if (code == LEN_CODE_5)
            r = LEN5;
        return r;
    endfunction

    function automatic logic lane_on(input len_t len, input int unsigned idx);
        logic r;
        r = 1'b0;
        unique case (len)
            LEN7:    r = (idx < 7);
            LEN5:    r = (idx < 5);
            default: r = (idx < 3);
        endcase
        return r;
    endfunction

    function automatic logic [DCOEF_W-1:0] dist_coef(input len_t len,
                                                     input int unsigned idx);
        logic [DCOEF_W-1:0] r;
        r = '0;
        unique case (len)
            LEN7:    if (idx < 7) r = DCOEF7[idx[2:0]];
            LEN5:    if (idx < 5) r = DCOEF5[idx[2:0]];
            default: if (idx < 3) r = DCOEF3[idx[1:0]];
        endcase
        return r;
    endfunction

    function automatic logic [TCOEF_W-1:0] clip_coef(input len_t len,
                                                     input int unsigned idx);
        logic [TCOEF_W-1:0] r;
        r = '0;
        unique case (len)
            LEN3:    if (idx < 3) r = TCOEF3[idx[1:0]];
            default: if (idx < 7) r = TCOEF7[idx[2:0]];
        endcase
        return r;
    endfunction

endpackage

// ----- design/vvclld_ref.sv -----
// ----------------------------------------------------------------------------
// vvclld_ref
// Reference values of one line: refMiddle by length pair, refP and refQ.
// ----------------------------------------------------------------------------
module vvclld_ref #(
    parameter int BIT_DEPTH = vvclld_pkg::BIT_DEPTH_DEFAULT
) (
    input  logic [BIT_DEPTH-1:0] p [vvclld_pkg::SIDE_N],
    input  logic [BIT_DEPTH-1:0] q [vvclld_pkg::SIDE_N],
    input  vvclld_pkg::ctrl_t    ctrl,
    output logic [BIT_DEPTH-1:0] mid,
    output logic [BIT_DEPTH-1:0] ref_p,
    output logic [BIT_DEPTH-1:0] ref_q
);

    // 16 weights of a full-scale sample plus rounding
    localparam int SW = BIT_DEPTH + 5;
    localparam int RW = BIT_DEPTH + 1;

    logic [SW-1:0] ep [vvclld_pkg::SIDE_N];
    logic [SW-1:0] eq [vvclld_pkg::SIDE_N];
    logic [SW-1:0] ea [vvclld_pkg::SIDE_N];   // long side for 7/3
    logic [SW-1:0] eb [vvclld_pkg::SIDE_N];   // short side for 7/3
    logic [SW-1:0] sum;
    logic [RW-1:0] rp_sum;
    logic [RW-1:0] rq_sum;

    always_comb
    begin
        for (int k = 0; k < vvclld_pkg::SIDE_N; k++)
        begin
            ep[k] = SW'(p[k]);
            eq[k] = SW'(q[k]);
            ea[k] = (ctrl.p_len == vvclld_pkg::LEN7) ? ep[k] : eq[k];
            eb[k] = (ctrl.p_len == vvclld_pkg::LEN7) ? eq[k] : ep[k];
        end
    end

    always_comb
    begin
        mid = '0;
        if (ctrl.p_len == ctrl.q_len && ctrl.p_len == vvclld_pkg::LEN5)
        begin
            sum = ((ep[0] + eq[0] + ep[1] + eq[1] + ep[2] + eq[2]) << 1)
                + ep[3] + eq[3] + ep[4] + eq[4] + SW'(8);
            mid = sum[SW-2:4];
        end
        else if (ctrl.p_len == ctrl.q_len && ctrl.p_len == vvclld_pkg::LEN7)
        begin
            sum = ((ep[0] + eq[0]) << 1) + ep[1] + eq[1] + ep[2] + eq[2]
                + ep[3] + eq[3] + ep[4] + eq[4] + ep[5] + eq[5]
                + ep[6] + eq[6] + SW'(8);
            mid = sum[SW-2:4];
        end
        else if ((ctrl.p_len == vvclld_pkg::LEN7 && ctrl.q_len == vvclld_pkg::LEN5)
              || (ctrl.p_len == vvclld_pkg::LEN5 && ctrl.q_len == vvclld_pkg::LEN7))
        begin
            sum = ((ep[0] + eq[0] + ep[1] + eq[1]) << 1) + ep[2] + eq[2]
                + ep[3] + eq[3] + ep[4] + eq[4] + ep[5] + eq[5] + SW'(8);
            mid = sum[SW-2:4];
        end
        else if ((ctrl.p_len == vvclld_pkg::LEN7 && ctrl.q_len == vvclld_pkg::LEN3)
              || (ctrl.p_len == vvclld_pkg::LEN3 && ctrl.q_len == vvclld_pkg::LEN7))
        begin
            sum = (ea[0] << 1) + (eb[0] << 1) + eb[0] + (eb[1] << 1) + eb[1]
                + (eb[2] << 1) + ea[1] + ea[2] + ea[3] + ea[4] + ea[5] + ea[6]
                + SW'(8);
            mid = sum[SW-2:4];
        end
        else
        begin
            // 5/3 pairs: eight-tap mean
            sum = ep[0] + eq[0] + ep[1] + eq[1] + ep[2] + eq[2] + ep[3] + eq[3]
                + SW'(4);
            mid = sum[SW-3:3];
        end
    end

    // Average of the two outermost taps on each side
    always_comb
    begin
        unique case (ctrl.p_len)
            vvclld_pkg::LEN7: rp_sum = RW'(p[7]) + RW'(p[6]) + RW'(1);
            vvclld_pkg::LEN5: rp_sum = RW'(p[5]) + RW'(p[4]) + RW'(1);
            default:          rp_sum = RW'(p[3]) + RW'(p[2]) + RW'(1);
        endcase
        unique case (ctrl.q_len)
            vvclld_pkg::LEN7: rq_sum = RW'(q[7]) + RW'(q[6]) + RW'(1);
            vvclld_pkg::LEN5: rq_sum = RW'(q[5]) + RW'(q[4]) + RW'(1);
            default:          rq_sum = RW'(q[3]) + RW'(q[2]) + RW'(1);
        endcase
    end

    assign ref_p = rp_sum[RW-1:1];
    assign ref_q = rq_sum[RW-1:1];

endmodule

// ----- design/vvclld_lane.sv -----
// ----------------------------------------------------------------------------
// vvclld_lane
// One sample position: blend refMiddle with the side reference, then clip
// to the sample +/- (tc * tcCoeff) >> 1.
// ----------------------------------------------------------------------------
module vvclld_lane #(
    parameter int BIT_DEPTH = vvclld_pkg::BIT_DEPTH_DEFAULT,
    parameter int LANE_IDX  = 0
) (
    input  logic [BIT_DEPTH-1:0]        mid,
    input  logic [BIT_DEPTH-1:0]        ref_side,
    input  logic [BIT_DEPTH-1:0]        smp,
    input  logic [vvclld_pkg::TC_W-1:0] tc,
    input  vvclld_pkg::len_t            len,
    output logic [BIT_DEPTH-1:0]        filt
);

    localparam int BW = BIT_DEPTH + 7;
    localparam int PW = vvclld_pkg::TC_W + vvclld_pkg::TCOEF_W;
    localparam int DW = ((BIT_DEPTH > vvclld_pkg::CLIP_W) ? BIT_DEPTH
                                                         : vvclld_pkg::CLIP_W) + 2;

    logic [vvclld_pkg::DCOEF_W:0]    dc;
    logic [vvclld_pkg::TCOEF_W-1:0]  tcc;
    logic [BW-1:0]                   blend;
    logic [PW-1:0]                   tc_prod;
    logic signed [DW-1:0]            v;
    logic signed [DW-1:0]            lo;
    logic signed [DW-1:0]            hi;
    logic signed [DW-1:0]            res;

    always_comb
    begin
        dc      = {1'b0, vvclld_pkg::dist_coef(len, LANE_IDX)};
        tcc     = vvclld_pkg::clip_coef(len, LANE_IDX);
        blend   = BW'(mid) * BW'(dc) + BW'(ref_side) * BW'(7'd64 - dc) + BW'(32);
        tc_prod = PW'(tc) * PW'(tcc);
        // blend >> 6 never leaves the sample range, so the 16-bit clamp is moot
        v       = DW'(blend[BW-1:6]);
        lo      = DW'(smp) - DW'(tc_prod[PW-1:1]);
        hi      = DW'(smp) + DW'(tc_prod[PW-1:1]);
        res     = v;
        if (res < lo)
            res = lo;
        if (res > hi)
            res = hi;
        filt    = res[BIT_DEPTH-1:0];
    end

endmodule

// ----- design/vvclld_merge.sv -----
// ----------------------------------------------------------------------------
// vvclld_merge
// Picks filtered or original sample per position and repacks the line.
// ----------------------------------------------------------------------------
module vvclld_merge #(
    parameter int BIT_DEPTH = vvclld_pkg::BIT_DEPTH_DEFAULT
) (
    input  logic [BIT_DEPTH-1:0]  p [vvclld_pkg::SIDE_N],
    input  logic [BIT_DEPTH-1:0]  q [vvclld_pkg::SIDE_N],
    input  logic [BIT_DEPTH-1:0]  p_filt [vvclld_pkg::LANE_N],
    input  logic [BIT_DEPTH-1:0]  q_filt [vvclld_pkg::LANE_N],
    input  vvclld_pkg::ctrl_t     ctrl,
    output vvclld_pkg::out_item_t item
);

    localparam int GW = 4 * BIT_DEPTH;
    localparam int WW = vvclld_pkg::WORD_W;

    logic [BIT_DEPTH-1:0] p_sel [vvclld_pkg::SIDE_N];
    logic [BIT_DEPTH-1:0] q_sel [vvclld_pkg::SIDE_N];
    logic [GW-1:0]        pn_w;
    logic [GW-1:0]        pf_w;
    logic [GW-1:0]        qn_w;
    logic [GW-1:0]        qf_w;

    always_comb
    begin
        for (int k = 0; k < vvclld_pkg::LANE_N; k++)
        begin
            p_sel[k] = (ctrl.active && vvclld_pkg::lane_on(ctrl.p_len, k)) ? p_filt[k] : p[k];
            q_sel[k] = (ctrl.active && vvclld_pkg::lane_on(ctrl.q_len, k)) ? q_filt[k] : q[k];
        end
        // outermost tap is never written
        p_sel[vvclld_pkg::SIDE_N-1] = p[vvclld_pkg::SIDE_N-1];
        q_sel[vvclld_pkg::SIDE_N-1] = q[vvclld_pkg::SIDE_N-1];

        for (int k = 0; k < 4; k++)
        begin
            pn_w[k*BIT_DEPTH +: BIT_DEPTH] = p_sel[k];
            pf_w[k*BIT_DEPTH +: BIT_DEPTH] = p_sel[k+4];
            qn_w[k*BIT_DEPTH +: BIT_DEPTH] = q_sel[k];
            qf_w[k*BIT_DEPTH +: BIT_DEPTH] = q_sel[k+4];
        end

        item.p_near_out = WW'(pn_w);
        item.p_far_out  = WW'(pf_w);
        item.q_near_out = WW'(qn_w);
        item.q_far_out  = WW'(qf_w);
    end

endmodule

// ----- design/vvc_long_luma_deblock_line.sv -----
// ----------------------------------------------------------------------------
// vvc_long_luma_deblock_line
// Long-tap luma deblocking filter for one line of samples across an edge.
// ----------------------------------------------------------------------------
// Takes one line per clock unless stalled by back-pressure on the result side.
// An item carries p0..p7 and q0..q7 (four samples per 40-bit field, sample 0
// in the low bits), tc and the two side lengths; lengths other than 5 or 7
// count as 3, and a 3/3 pair passes the line through unchanged. Stage one
// registers the unpacked samples together with refMiddle, refP and refQ;
// stage two runs fourteen filter lanes (seven per side) in parallel, merges
// them with the untouched samples and lands in the output register. Both
// stages hold under back-pressure and refill as soon as the result is
// taken, so the block sustains one item per cycle while results are taken.
// Samples are BIT_DEPTH bits; result bits above 4*BIT_DEPTH are zero, and at
// BIT_DEPTH above 10 the packed samples are cut to the 40-bit field.
// ----------------------------------------------------------------------------
module vvc_long_luma_deblock_line #(
    parameter int BIT_DEPTH = vvclld_pkg::BIT_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  line_valid,
    output logic                  line_ready,
    input  vvclld_pkg::in_item_t  line_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output vvclld_pkg::out_item_t result_item
);

    localparam int GW = 4 * BIT_DEPTH;
    localparam int NS = vvclld_pkg::SIDE_N;
    localparam int NL = vvclld_pkg::LANE_N;

    // ---- handshake / pipeline control ----
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s1_load;
    logic out_load;

    // ---- stage 0: unpack and reference values ----
    logic [GW-1:0]          pn_ext, pf_ext, qn_ext, qf_ext;
    logic [BIT_DEPTH-1:0]   p_in [NS];
    logic [BIT_DEPTH-1:0]   q_in [NS];
    vvclld_pkg::ctrl_t      ctrl_in;
    logic [BIT_DEPTH-1:0]   mid_in, ref_p_in, ref_q_in;

    // ---- stage 1 registers ----
    logic [BIT_DEPTH-1:0]        p_reg [NS];
    logic [BIT_DEPTH-1:0]        q_reg [NS];
    logic [BIT_DEPTH-1:0]        mid_reg, ref_p_reg, ref_q_reg;
    logic [vvclld_pkg::TC_W-1:0] tc_reg;
    vvclld_pkg::ctrl_t           ctrl_reg;

    // ---- stage 2: lanes and merge ----
    logic [BIT_DEPTH-1:0]   p_filt [NL];
    logic [BIT_DEPTH-1:0]   q_filt [NL];
    vvclld_pkg::out_item_t  merged;
    vvclld_pkg::out_item_t  result_reg;

    // Output register loads when empty or being drained; stage one loads
    // when it is empty or can hand its line on.
    assign out_load   = !out_valid_reg || result_ready;
    assign s1_load    = !s1_valid_reg || out_load;
    assign line_ready = s1_load;

    always_comb
    begin
        s1_valid_next  = s1_load ? line_valid : s1_valid_reg;
        out_valid_next = out_load ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Unpack four samples per field
    always_comb
    begin
        pn_ext = GW'(line_item.p_near);
        pf_ext = GW'(line_item.p_far);
        qn_ext = GW'(line_item.q_near);
        qf_ext = GW'(line_item.q_far);
        for (int k = 0; k < 4; k++)
        begin
            p_in[k]   = pn_ext[k*BIT_DEPTH +: BIT_DEPTH];
            p_in[k+4] = pf_ext[k*BIT_DEPTH +: BIT_DEPTH];
            q_in[k]   = qn_ext[k*BIT_DEPTH +: BIT_DEPTH];
            q_in[k+4] = qf_ext[k*BIT_DEPTH +: BIT_DEPTH];
        end
        ctrl_in.p_len  = vvclld_pkg::norm_len(line_item.p_length);
        ctrl_in.q_len  = vvclld_pkg::norm_len(line_item.q_length);
        ctrl_in.active = !(ctrl_in.p_len == vvclld_pkg::LEN3
                           && ctrl_in.q_len == vvclld_pkg::LEN3);
    end

    vvclld_ref #(
        .BIT_DEPTH (BIT_DEPTH)
    ) u_ref (
        .p     (p_in),
        .q     (q_in),
        .ctrl  (ctrl_in),
        .mid   (mid_in),
        .ref_p (ref_p_in),
        .ref_q (ref_q_in)
    );

    always_ff @(posedge clk)
    begin
        if (s1_load && line_valid)
        begin
            p_reg     <= p_in;
            q_reg     <= q_in;
            mid_reg   <= mid_in;
            ref_p_reg <= ref_p_in;
            ref_q_reg <= ref_q_in;
            tc_reg    <= line_item.tc;
            ctrl_reg  <= ctrl_in;
        end
    end

    // Seven lanes per side; lanes past the side length are masked in merge
    for (genvar i = 0; i < NL; i++)
    begin : g_lane
        vvclld_lane #(
            .BIT_DEPTH (BIT_DEPTH),
            .LANE_IDX  (i)
        ) u_p_lane (
            .mid      (mid_reg),
            .ref_side (ref_p_reg),
            .smp      (p_reg[i]),
            .tc       (tc_reg),
            .len      (ctrl_reg.p_len),
            .filt     (p_filt[i])
        );

        vvclld_lane #(
            .BIT_DEPTH (BIT_DEPTH),
            .LANE_IDX  (i)
        ) u_q_lane (
            .mid      (mid_reg),
            .ref_side (ref_q_reg),
            .smp      (q_reg[i]),
            .tc       (tc_reg),
            .len      (ctrl_reg.q_len),
            .filt     (q_filt[i])
        );
    end

    vvclld_merge #(
        .BIT_DEPTH (BIT_DEPTH)
    ) u_merge (
        .p      (p_reg),
        .q      (q_reg),
        .p_filt (p_filt),
        .q_filt (q_filt),
        .ctrl   (ctrl_reg),
        .item   (merged)
    );

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
            result_reg <= merged;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = result_reg;

endmodule

// ----- sim/vvclld_line_checker.sv -----
// ----------------------------------------------------------------------------
// vvclld_line_checker
// Watches both item channels of the long luma deblocking line filter, works
// out the filtered line for every accepted input item and compares each
// returned item field by field, oldest first.
// ----------------------------------------------------------------------------
module vvclld_line_checker #(
    parameter int BIT_DEPTH = vvclld_pkg::BIT_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  line_valid,
    input  logic                  line_ready,
    input  vvclld_pkg::in_item_t  line_item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  vvclld_pkg::out_item_t result_item,
    output int                    outstanding,
    output int                    mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    vvclld_pkg::out_item_t filtered_due [$];
    vvclld_pkg::out_item_t oldest;
    int                    bad_fields = 0;

    assign mismatches = bad_fields;

    function automatic int side_len(input logic [vvclld_pkg::LEN_W-1:0] code);
        if (code == vvclld_pkg::LEN_CODE_7)
            return 7;
        if (code == vvclld_pkg::LEN_CODE_5)
            return 5;
        return 3;
    endfunction

    // distance weights fall in equal steps: 59-9i, 58-13i, 53-21i
    function automatic int dist_weight(input int len, input int i);
        if (len == 7)
            return 59 - 9 * i;
        if (len == 5)
            return 58 - 13 * i;
        return 53 - 21 * i;
    endfunction

    // clip weights: 6,4,2 for short sides, else 6,5,4,3,2,1,1
    function automatic int clip_weight(input int len, input int i);
        if (len == 3)
            return 6 - 2 * i;
        return (i < 5) ? 6 - i : 1;
    endfunction

    function automatic int tap_out(input int mid, input int side_ref, input int sample,
                                   input int dw, input int tw, input int tc);
        int lim;
        int v;
        lim = (tc * tw) >>> 1;
        v = (mid * dw + side_ref * (64 - dw) + 32) >>> 6;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        if (v < sample - lim)
            v = sample - lim;
        if (v > sample + lim)
            v = sample + lim;
        return v;
    endfunction

    function automatic vvclld_pkg::out_item_t filter_line(input vvclld_pkg::in_item_t it);
        int                    p [8];
        int                    q [8];
        int                    a [8];
        int                    b [8];
        int                    lp;
        int                    lq;
        int                    tcv;
        int                    mid;
        int                    ref_p;
        int                    ref_q;
        vvclld_pkg::out_item_t r;
        lp  = side_len(it.p_length);
        lq  = side_len(it.q_length);
        tcv = int'(it.tc);
        for (int k = 0; k < 4; k++)
        begin
            p[k]     = int'(it.p_near[k*BIT_DEPTH +: BIT_DEPTH]);
            p[k + 4] = int'(it.p_far[k*BIT_DEPTH +: BIT_DEPTH]);
            q[k]     = int'(it.q_near[k*BIT_DEPTH +: BIT_DEPTH]);
            q[k + 4] = int'(it.q_far[k*BIT_DEPTH +: BIT_DEPTH]);
        end
        // a 3/3 pair is not a long filter: the line passes through
        if (!(lp == 3 && lq == 3))
        begin
            if (lp == lq && lp == 5)
                mid = (2 * (p[0] + q[0] + p[1] + q[1] + p[2] + q[2])
                       + p[3] + q[3] + p[4] + q[4] + 8) >>> 4;
            else if (lp == lq)
                mid = (2 * (p[0] + q[0]) + p[1] + q[1] + p[2] + q[2] + p[3] + q[3]
                       + p[4] + q[4] + p[5] + q[5] + p[6] + q[6] + 8) >>> 4;
            else if (lp + lq == 12)
                mid = (2 * (p[0] + q[0] + p[1] + q[1]) + p[2] + q[2] + p[3] + q[3]
                       + p[4] + q[4] + p[5] + q[5] + 8) >>> 4;
            else if (lp + lq == 10)
            begin
                // 7 against 3: a is the long side, b the short one
                if (lp == 7)
                begin
                    a = p;
                    b = q;
                end
                else
                begin
                    a = q;
                    b = p;
                end
                mid = (2 * a[0] + 3 * b[0] + 3 * b[1] + 2 * b[2] + a[1] + a[2] + a[3]
                       + a[4] + a[5] + a[6] + 8) >>> 4;
            end
            else
                mid = (p[0] + q[0] + p[1] + q[1] + p[2] + q[2] + p[3] + q[3] + 4) >>> 3;
            ref_p = (p[lp] + p[lp - 1] + 1) >>> 1;
            ref_q = (q[lq] + q[lq - 1] + 1) >>> 1;
            for (int i = 0; i < lp; i++)
                p[i] = tap_out(mid, ref_p, p[i], dist_weight(lp, i), clip_weight(lp, i), tcv);
            for (int i = 0; i < lq; i++)
                q[i] = tap_out(mid, ref_q, q[i], dist_weight(lq, i), clip_weight(lq, i), tcv);
        end
        r = '0;
        for (int k = 0; k < 4; k++)
        begin
            r.p_near_out[k*BIT_DEPTH +: BIT_DEPTH] = BIT_DEPTH'(p[k]);
            r.p_far_out[k*BIT_DEPTH +: BIT_DEPTH]  = BIT_DEPTH'(p[k + 4]);
            r.q_near_out[k*BIT_DEPTH +: BIT_DEPTH] = BIT_DEPTH'(q[k]);
            r.q_far_out[k*BIT_DEPTH +: BIT_DEPTH]  = BIT_DEPTH'(q[k + 4]);
        end
        return r;
    endfunction

    task automatic flag(input string what, input logic [vvclld_pkg::WORD_W-1:0] got,
                        input logic [vvclld_pkg::WORD_W-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        bad_fields++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (line_valid && line_ready)
                filtered_due.push_back(filter_line(line_item));
            if (result_valid && result_ready)
            begin
                if (filtered_due.size() == 0)
                    flag("result with nothing due, p_near_out", result_item.p_near_out, '0);
                else
                begin
                    oldest = filtered_due.pop_front();
                    if (result_item.p_near_out !== oldest.p_near_out)
                        flag("p_near_out", result_item.p_near_out, oldest.p_near_out);
                    if (result_item.p_far_out !== oldest.p_far_out)
                        flag("p_far_out", result_item.p_far_out, oldest.p_far_out);
                    if (result_item.q_near_out !== oldest.q_near_out)
                        flag("q_near_out", result_item.q_near_out, oldest.q_near_out);
                    if (result_item.q_far_out !== oldest.q_far_out)
                        flag("q_far_out", result_item.q_far_out, oldest.q_far_out);
                end
            end
        end
        outstanding <= filtered_due.size();
    end

endmodule

// ----- sim/tb_vvc_long_luma_deblock_line.sv -----
// ----------------------------------------------------------------------------
// tb_vvc_long_luma_deblock_line
// Drives lines of samples into the long luma deblocking filter and judges it.
// ----------------------------------------------------------------------------
// A directed pass covers every pair of side lengths, unlisted length codes,
// flat, step and alternating lines at the sample extremes, and tc at zero and
// full scale. A random pass follows with smooth, stepped and noisy lines plus
// some malformed length codes. Both channels idle at random, with one long
// stretch at full rate. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_vvc_long_luma_deblock_line;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BIT_DEPTH    = vvclld_pkg::BIT_DEPTH_DEFAULT;
    localparam int SAMPLE_MAX   = (1 << BIT_DEPTH) - 1;
    localparam int RANDOM_LINES = 800;
    localparam int QUIET_LIMIT  = 1000;   // cycles with no handshake at all
    localparam int LW           = vvclld_pkg::LEN_W;
    localparam int TW           = vvclld_pkg::TC_W;
    localparam int WW           = vvclld_pkg::WORD_W;

    // Length codes: 3, 5 and 7 are the legal ones, the rest fold onto 3
    localparam logic [LW-1:0] LEN_CODE_3 = 3'd3;
    localparam logic [LW-1:0] LEN_ODD_0  = 3'd0;
    localparam logic [LW-1:0] LEN_ODD_1  = 3'd1;
    localparam logic [LW-1:0] LEN_ODD_2  = 3'd2;
    localparam logic [LW-1:0] LEN_ODD_4  = 3'd4;
    localparam logic [LW-1:0] LEN_ODD_6  = 3'd6;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  line_valid   = 1'b0;
    logic                  line_ready;
    vvclld_pkg::in_item_t  line_item    = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    vvclld_pkg::out_item_t result_item;

    logic      steady = 1'b0;   // set: neither side idles
    int        outstanding;
    int        mismatches;
    int        quiet;

    vvc_long_luma_deblock_line #(
        .BIT_DEPTH (BIT_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_valid   (line_valid),
        .line_ready   (line_ready),
        .line_item    (line_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    vvclld_line_checker #(
        .BIT_DEPTH (BIT_DEPTH)
    ) line_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_valid   (line_valid),
        .line_ready   (line_ready),
        .line_item    (line_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side stalls about 27 percent of the time, except in the steady stretch
    always @(posedge clk)
        result_ready <= steady || ($urandom_range(99) >= 27);

    // Watchdog: any handshake on either channel restarts the count
    initial
    begin
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((line_valid && line_ready) || (result_valid && result_ready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [LW-1:0] pair_code(input int sel);
        if (sel == 0)
            return LEN_CODE_3;
        if (sel == 1)
            return vvclld_pkg::LEN_CODE_5;
        return vvclld_pkg::LEN_CODE_7;
    endfunction

    function automatic int clamp_sample(input int v);
        if (v < 0)
            return 0;
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        return v;
    endfunction

    // Sample near a base level, within +/- 6
    function automatic int jitter(input int base);
        int j;
        j = $urandom_range(12);
        return clamp_sample(base + j - 6);
    endfunction

    // Every sample on a side at one level
    function automatic vvclld_pkg::in_item_t flat_line(input int pv, input int qv,
                                                       input int tcv,
                                                       input logic [LW-1:0] lp,
                                                       input logic [LW-1:0] lq);
        vvclld_pkg::in_item_t it;
        it = '0;
        for (int k = 0; k < 4; k++)
        begin
            it.p_near[k*BIT_DEPTH +: BIT_DEPTH] = BIT_DEPTH'(pv);
            it.p_far[k*BIT_DEPTH +: BIT_DEPTH]  = BIT_DEPTH'(pv);
            it.q_near[k*BIT_DEPTH +: BIT_DEPTH] = BIT_DEPTH'(qv);
            it.q_far[k*BIT_DEPTH +: BIT_DEPTH]  = BIT_DEPTH'(qv);
        end
        it.tc       = TW'(tcv);
        it.p_length = lp;
        it.q_length = lq;
        return it;
    endfunction

    // Mostly legal length pairs over noisy, smooth or stepped lines; one in
    // ten carries arbitrary length codes
    function automatic vvclld_pkg::in_item_t random_line();
        vvclld_pkg::in_item_t it;
        int                   shape;
        int                   base_p;
        int                   base_q;
        int                   j;
        shape = $urandom_range(9);
        it.tc = $urandom_range(1) ? TW'($urandom_range(40)) : TW'($urandom_range(1023));
        if (shape < 4)
        begin
            it.p_near = WW'({$urandom, $urandom});
            it.p_far  = WW'({$urandom, $urandom});
            it.q_near = WW'({$urandom, $urandom});
            it.q_far  = WW'({$urandom, $urandom});
        end
        else
        begin
            base_p = $urandom_range(SAMPLE_MAX);
            j      = $urandom_range(40);
            // smooth lines stay close across the edge, stepped ones jump
            base_q = (shape < 7) ? clamp_sample(base_p + j - 20) : $urandom_range(SAMPLE_MAX);
            for (int k = 0; k < 4; k++)
            begin
                it.p_near[k*BIT_DEPTH +: BIT_DEPTH] = BIT_DEPTH'(jitter(base_p));
                it.p_far[k*BIT_DEPTH +: BIT_DEPTH]  = BIT_DEPTH'(jitter(base_p));
                it.q_near[k*BIT_DEPTH +: BIT_DEPTH] = BIT_DEPTH'(jitter(base_q));
                it.q_far[k*BIT_DEPTH +: BIT_DEPTH]  = BIT_DEPTH'(jitter(base_q));
            end
        end
        if (shape == 0)
        begin
            it.p_length = LW'($urandom_range(7));
            it.q_length = LW'($urandom_range(7));
        end
        else
        begin
            do
            begin
                it.p_length = pair_code($urandom_range(2));
                it.q_length = pair_code($urandom_range(2));
            end while (it.p_length == LEN_CODE_3 && it.q_length == LEN_CODE_3);
        end
        return it;
    endfunction

    // Offer one item, idling first at random; returns in the step that took
    // it, so a following item keeps valid high without a dip.
    task automatic push_line(input vvclld_pkg::in_item_t it);
        logic took;
        while (!steady && $urandom_range(99) < 27)
        begin
            line_valid <= 1'b0;
            @(posedge clk);
        end
        line_valid <= 1'b1;
        line_item  <= it;
        // ready is stable from the falling edge up to the rising one
        do
        begin
            @(negedge clk);
            took = line_ready;
            @(posedge clk);
        end while (!took);
    endtask

    // Hold the input side quiet until every filtered line is back
    task automatic drain_results();
        line_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        vvclld_pkg::in_item_t it;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // every pairing of the three legal lengths, 3/3 being pass-through
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
            begin
                it          = random_line();
                it.p_length = pair_code(a);
                it.q_length = pair_code(b);
                push_line(it);
            end

        // unlisted codes fold onto 3
        it = random_line();
        it.p_length = LEN_ODD_0;
        it.q_length = vvclld_pkg::LEN_CODE_7;
        push_line(it);
        it = random_line();
        it.p_length = vvclld_pkg::LEN_CODE_7;
        it.q_length = LEN_ODD_4;
        push_line(it);
        it = random_line();
        it.p_length = LEN_ODD_6;
        it.q_length = vvclld_pkg::LEN_CODE_5;
        push_line(it);
        it = random_line();
        it.p_length = LEN_ODD_1;
        it.q_length = LEN_ODD_2;
        push_line(it);

        // extremes: flat black, flat white, hard steps at full tc
        push_line(flat_line(0, 0, 0, vvclld_pkg::LEN_CODE_7, vvclld_pkg::LEN_CODE_7));
        push_line(flat_line(SAMPLE_MAX, SAMPLE_MAX, 1023,
                            vvclld_pkg::LEN_CODE_7, vvclld_pkg::LEN_CODE_7));
        push_line(flat_line(0, SAMPLE_MAX, 1023, vvclld_pkg::LEN_CODE_7, LEN_CODE_3));
        push_line(flat_line(SAMPLE_MAX, 0, 1023, LEN_CODE_3, vvclld_pkg::LEN_CODE_7));
        push_line(flat_line(0, SAMPLE_MAX, 1023,
                            vvclld_pkg::LEN_CODE_5, vvclld_pkg::LEN_CODE_5));

        // alternating black/white samples, opposite phase on each side
        it = flat_line(0, 0, 1023, vvclld_pkg::LEN_CODE_5, vvclld_pkg::LEN_CODE_7);
        for (int k = 0; k < 4; k++)
        begin
            it.p_near[k*BIT_DEPTH +: BIT_DEPTH] = (k % 2) ? BIT_DEPTH'(SAMPLE_MAX) : '0;
            it.p_far[k*BIT_DEPTH +: BIT_DEPTH]  = (k % 2) ? BIT_DEPTH'(SAMPLE_MAX) : '0;
            it.q_near[k*BIT_DEPTH +: BIT_DEPTH] = (k % 2) ? '0 : BIT_DEPTH'(SAMPLE_MAX);
            it.q_far[k*BIT_DEPTH +: BIT_DEPTH]  = (k % 2) ? '0 : BIT_DEPTH'(SAMPLE_MAX);
        end
        push_line(it);

        // zero tc clamps every tap back to its input
        it          = random_line();
        it.tc       = '0;
        it.p_length = vvclld_pkg::LEN_CODE_7;
        it.q_length = vvclld_pkg::LEN_CODE_5;
        push_line(it);

        drain_results();

        for (int n = 0; n < RANDOM_LINES; n++)
        begin
            steady = (n >= 300 && n < 420);
            if (n == 550)
                drain_results();
            push_line(random_line());
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
